// ===== rtl/point_to_panorama_pixel_defines.svh =====
// assertion macros for the point to panorama pixel block
`ifndef POINT_TO_PANORAMA_PIXEL_DEFINES_SVH
`define POINT_TO_PANORAMA_PIXEL_DEFINES_SVH

// same-cycle implication on clk, held off during reset
`define PTPP_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ptpp assertion failed");

// next-cycle implication on clk, held off during reset
`define PTPP_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("ptpp assertion failed");

`endif

// ===== rtl/ptpp_pkg.sv =====
// shared constants and types for the point to panorama pixel block
`timescale 1ns / 1ps

package ptpp_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_TAB_LEN  = 24;
    localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;
    localparam int PRESCALE_BITS = 16;

    localparam int COORD_W = 32;
    localparam int VEC_W   = 34;
    localparam int CW      = 52;
    localparam int AW      = 34;
    localparam int SQ_W    = 64;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = 36;
    localparam int QUO_W   = 31;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int MINR_W     = 32;
    localparam int PW_W       = 15;
    localparam int PH_W       = 14;
    localparam int COL_W      = 14;
    localparam int ROW_W      = 13;

    localparam logic [MINR_W-1:0] MIN_RANGE_RST = 32'd19661;
    localparam logic [PW_W-1:0]   PANO_W_RST    = 15'd6720;
    localparam logic [PH_W-1:0]   PANO_H_RST    = 14'd3360;

    localparam int COL_CAP = 16383;
    localparam int ROW_CAP = 8191;

    localparam int CORDIC_LAT = CORDIC_RUN + 1;
    localparam int SQRT_LAT   = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int ST_SQ_IN   = 3;
    localparam int ST_FLAG    = 4;
    localparam int ST_ROOT    = ST_SQ_IN + SQRT_LAT;
    localparam int ST_ANG_A   = CORDIC_LAT;
    localparam int ST_ANG_B   = ST_ROOT + CORDIC_LAT;
    localparam int ST_QUO     = ST_ROOT + DIV_STEPS;
    localparam int ST_OUT     = ST_QUO + 3;

    localparam logic [31:0] ATAN_TURNS [ATAN_TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RANGE   = 2'd0,
        CFG_PANO_WIDTH  = 2'd1,
        CFG_PANO_HEIGHT = 2'd2
    } cfg_idx_t;

endpackage

// ===== rtl/ptpp_if.sv =====
// point and pixel stream interfaces
`timescale 1ns / 1ps

interface ptpp_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [ptpp_pkg::COORD_W-1:0] pos_x;
    logic signed [ptpp_pkg::COORD_W-1:0] pos_y;
    logic signed [ptpp_pkg::COORD_W-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface ptpp_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [ptpp_pkg::COL_W-1:0]      pixel_col;
    logic [ptpp_pkg::ROW_W-1:0]      pixel_row;
    logic                            skipped;

    modport source (output valid, output pixel_col, output pixel_row, output skipped,
                    input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input skipped,
                    output ready);
endinterface

// ===== rtl/ptpp_sqrt.sv =====
// pipelined floor square root, one root bit per stage
`timescale 1ns / 1ps

module ptpp_sqrt (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [ptpp_pkg::SQ_W-1:0]     radicand,
    output logic [ptpp_pkg::ROOT_W-1:0]   root
);

    localparam int N    = ptpp_pkg::ROOT_W;
    localparam int SW   = ptpp_pkg::SQ_W;
    localparam int RW   = ptpp_pkg::REM_W;

    logic [SW-1:0] v_reg    [1:N-1];
    logic [RW-1:0] rem_reg  [1:N-1];
    logic [N-1:0]  root_reg [1:N];

    logic [SW-1:0] v_in     [0:N-1];
    logic [RW-1:0] rem_in   [0:N-1];
    logic [N-1:0]  root_in  [0:N-1];
    logic [RW-1:0] rem_s    [0:N-1];
    logic [RW-1:0] trial    [0:N-1];
    logic          ge       [0:N-1];
    logic [SW-1:0] v_next   [0:N-2];
    logic [RW-1:0] rem_next [0:N-2];
    logic [N-1:0]  root_next[0:N-1];

    always_comb
    begin
        v_in[0]    = radicand;
        rem_in[0]  = '0;
        root_in[0] = '0;
        for (int k = 1; k < N; k++)
        begin
            v_in[k]    = v_reg[k];
            rem_in[k]  = rem_reg[k];
            root_in[k] = root_reg[k];
        end
        for (int k = 0; k < N; k++)
        begin
            rem_s[k]     = {rem_in[k][RW-3:0], v_in[k][SW-1 -: 2]};
            trial[k]     = {2'b00, root_in[k], 2'b01};
            ge[k]        = (rem_s[k] >= trial[k]);
            root_next[k] = {root_in[k][N-2:0], ge[k]};
        end
        for (int k = 0; k < N - 1; k++)
        begin
            v_next[k]   = {v_in[k][SW-3:0], 2'b00};
            rem_next[k] = ge[k] ? (rem_s[k] - trial[k]) : rem_s[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N - 1; k++)
            begin
                v_reg[k+1]   <= v_next[k];
                rem_reg[k+1] <= rem_next[k];
            end
            for (int k = 0; k < N; k++)
            begin
                root_reg[k+1] <= root_next[k];
            end
        end
    end

    assign root = root_reg[N];

endmodule

// ===== rtl/ptpp_cordic.sv =====
// pipelined vectoring cordic giving the binary angle of a vector
`timescale 1ns / 1ps

module ptpp_cordic (
    input  logic                               clk,
    input  logic                               adv,
    input  logic signed [ptpp_pkg::VEC_W-1:0]  vec_x,
    input  logic signed [ptpp_pkg::VEC_W-1:0]  vec_y,
    output logic signed [ptpp_pkg::AW-1:0]     angle
);

    localparam int RUN = ptpp_pkg::CORDIC_RUN;
    localparam int CW  = ptpp_pkg::CW;
    localparam int AW  = ptpp_pkg::AW;
    localparam int VW  = ptpp_pkg::VEC_W;
    localparam logic signed [AW-1:0] HALF_TURN = AW'(64'd2147483648);

    logic signed [CW-1:0] x_reg [0:RUN-1];
    logic signed [CW-1:0] y_reg [0:RUN-1];
    logic signed [AW-1:0] a_reg [0:RUN];

    logic signed [VW-1:0] x_pre;
    logic signed [VW-1:0] y_pre;
    logic signed [AW-1:0] a_pre;
    logic signed [CW-1:0] dx   [0:RUN-1];
    logic signed [CW-1:0] dy   [0:RUN-1];
    logic signed [AW-1:0] da   [0:RUN-1];
    logic signed [AW-1:0] a_nx [0:RUN-1];
    logic signed [CW-1:0] x_nx [0:RUN-2];
    logic signed [CW-1:0] y_nx [0:RUN-2];

    // half-turn pre-rotation into the right half plane
    always_comb
    begin
        x_pre = vec_x;
        y_pre = vec_y;
        a_pre = '0;
        if (vec_x < 0)
        begin
            a_pre = (vec_y >= 0) ? HALF_TURN : -HALF_TURN;
            x_pre = -vec_x;
            y_pre = -vec_y;
        end
    end

    always_comb
    begin
        for (int i = 0; i < RUN; i++)
        begin
            dx[i]   = y_reg[i] >>> i;
            dy[i]   = x_reg[i] >>> i;
            da[i]   = $signed(AW'({1'b0, ptpp_pkg::ATAN_TURNS[i]}));
            a_nx[i] = (y_reg[i] >= 0) ? (a_reg[i] + da[i]) : (a_reg[i] - da[i]);
        end
        for (int i = 0; i < RUN - 1; i++)
        begin
            x_nx[i] = (y_reg[i] >= 0) ? (x_reg[i] + dx[i]) : (x_reg[i] - dx[i]);
            y_nx[i] = (y_reg[i] >= 0) ? (y_reg[i] - dy[i]) : (y_reg[i] + dy[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= CW'(x_pre) <<< ptpp_pkg::PRESCALE_BITS;
            y_reg[0] <= CW'(y_pre) <<< ptpp_pkg::PRESCALE_BITS;
            a_reg[0] <= a_pre;
            for (int i = 0; i < RUN - 1; i++)
            begin
                x_reg[i+1] <= x_nx[i];
                y_reg[i+1] <= y_nx[i];
            end
            for (int i = 0; i < RUN; i++)
            begin
                a_reg[i+1] <= a_nx[i];
            end
        end
    end

    assign angle = a_reg[RUN];

endmodule

// ===== rtl/point_to_panorama_pixel.sv =====
// top level: maps a 3d point to a panorama pixel, azimuth scaled by the elevation cosine
//
//   port   | direction | carries
//   -------+-----------+---------------------------------------------
//   pt     | in        | pos_x, pos_y, pos_z (signed q16.16)
//   px     | out       | pixel_col, pixel_row, skipped
//   cfg_*  | in        | min_range, pano_width, pano_height writes
//
// one point per cycle while no held result stalls the pipeline
// each point runs through the 32-step square roots and the 31-step divider
// reset clears valid bits and loads default configuration
// a held result freezes every stage at once; nothing is lost or repeated
`timescale 1ns / 1ps
`include "point_to_panorama_pixel_defines.svh"

module point_to_panorama_pixel (
    input  logic                                 clk,
    input  logic                                 rst_n,
    ptpp_point_if.sink                           pt,
    ptpp_pixel_if.source                         px,
    input  logic                                 cfg_we,
    input  logic [ptpp_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [ptpp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW      = ptpp_pkg::AW;
    localparam int VW      = ptpp_pkg::VEC_W;
    localparam int RTW     = ptpp_pkg::ROOT_W;
    localparam int QW      = ptpp_pkg::QUO_W;
    localparam int NDIV    = ptpp_pkg::DIV_STEPS;
    localparam int ST_OUT  = ptpp_pkg::ST_OUT;
    localparam int ST_QUO  = ptpp_pkg::ST_QUO;
    localparam int ST_ROOT = ptpp_pkg::ST_ROOT;
    localparam int ST_FLAG = ptpp_pkg::ST_FLAG;
    localparam int ST_A    = ptpp_pkg::ST_ANG_A;
    localparam int ST_B    = ptpp_pkg::ST_ANG_B;
    localparam int PW      = ptpp_pkg::PW_W;
    localparam int PH      = ptpp_pkg::PH_W;

    // configuration
    logic [ptpp_pkg::MINR_W-1:0] min_range_reg;
    logic [PW-1:0]               pano_width_reg;
    logic [PH-1:0]               pano_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg   <= ptpp_pkg::MIN_RANGE_RST;
            pano_width_reg  <= ptpp_pkg::PANO_W_RST;
            pano_height_reg <= ptpp_pkg::PANO_H_RST;
        end
        else if (cfg_we)
        begin
            case (ptpp_pkg::cfg_idx_t'(cfg_idx))
                ptpp_pkg::CFG_MIN_RANGE:   min_range_reg   <= cfg_data;
                ptpp_pkg::CFG_PANO_WIDTH:  pano_width_reg  <= cfg_data[PW-1:0];
                ptpp_pkg::CFG_PANO_HEIGHT: pano_height_reg <= cfg_data[PH-1:0];
                default: ;
            endcase
        end
    end

    // valid chain and global stall
    logic [ST_OUT:0] vld_reg;
    logic            adv;

    assign adv      = !vld_reg[ST_OUT] || px.ready;
    assign pt.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[ST_OUT-1:0], pt.valid};
        end
    end

    // front stages: squares, sums, range test
    logic signed [31:0]  x_reg;
    logic signed [31:0]  y_reg;
    logic signed [32:0]  z_reg;
    logic [63:0]         xx_reg;
    logic [63:0]         yy_reg;
    logic [63:0]         zz_reg;
    logic [63:0]         zz2_reg;
    logic [63:0]         rho2_reg;
    logic [63:0]         rho2_s3_reg;
    logic [63:0]         d2_reg;
    logic [63:0]         m2_reg;
    logic                skip_reg [ST_FLAG:ST_OUT-1];
    logic                zero_reg [ST_FLAG:ST_OUT-1];
    logic signed [32:0]  z_pipe   [1:ST_ROOT];
    logic signed [63:0]  xx_full;
    logic signed [63:0]  yy_full;
    logic signed [65:0]  zz_full;
    logic signed [32:0]  z_next;

    always_comb
    begin
        z_next  = -$signed({pt.pos_z[31], pt.pos_z});
        xx_full = x_reg * x_reg;
        yy_full = y_reg * y_reg;
        zz_full = z_reg * z_reg;
    end

    always_ff @(posedge clk)
    begin
        m2_reg <= 64'(min_range_reg) * 64'(min_range_reg);
        if (adv)
        begin
            x_reg       <= pt.pos_x;
            y_reg       <= pt.pos_y;
            z_reg       <= z_next;
            xx_reg      <= xx_full;
            yy_reg      <= yy_full;
            zz_reg      <= zz_full[63:0];
            rho2_reg    <= xx_reg + yy_reg;
            zz2_reg     <= zz_reg;
            d2_reg      <= rho2_reg + zz2_reg;
            rho2_s3_reg <= rho2_reg;
            skip_reg[ST_FLAG] <= (d2_reg < m2_reg);
            zero_reg[ST_FLAG] <= (d2_reg == '0);
            for (int s = ST_FLAG; s < ST_OUT - 1; s++)
            begin
                skip_reg[s+1] <= skip_reg[s];
                zero_reg[s+1] <= zero_reg[s];
            end
            z_pipe[1] <= z_reg;
            for (int s = 1; s < ST_ROOT; s++)
            begin
                z_pipe[s+1] <= z_pipe[s];
            end
        end
    end

    // square roots of the horizontal and full range
    logic [RTW-1:0] rho_w;
    logic [RTW-1:0] r_w;

    ptpp_sqrt u_sqrt_rho (
        .clk      (clk),
        .adv      (adv),
        .radicand (rho2_s3_reg),
        .root     (rho_w)
    );

    ptpp_sqrt u_sqrt_r (
        .clk      (clk),
        .adv      (adv),
        .radicand (d2_reg),
        .root     (r_w)
    );

    // azimuth and elevation angles
    logic signed [AW-1:0] ang_a_w;
    logic signed [AW-1:0] ang_b_w;
    logic signed [AW-1:0] ang_a_pipe [ST_A+1:ST_QUO];
    logic signed [AW-1:0] ang_b_pipe [ST_B+1:ST_QUO];

    ptpp_cordic u_cordic_az (
        .clk   (clk),
        .adv   (adv),
        .vec_x (VW'(x_reg)),
        .vec_y (VW'(y_reg)),
        .angle (ang_a_w)
    );

    ptpp_cordic u_cordic_el (
        .clk   (clk),
        .adv   (adv),
        .vec_x ($signed(VW'(rho_w))),
        .vec_y (VW'(z_pipe[ST_ROOT])),
        .angle (ang_b_w)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_a_pipe[ST_A+1] <= ang_a_w;
            for (int s = ST_A + 1; s < ST_QUO; s++)
            begin
                ang_a_pipe[s+1] <= ang_a_pipe[s];
            end
            ang_b_pipe[ST_B+1] <= ang_b_w;
            for (int s = ST_B + 1; s < ST_QUO; s++)
            begin
                ang_b_pipe[s+1] <= ang_b_pipe[s];
            end
        end
    end

    // restoring divider for the elevation cosine rho * 2^30 / r
    logic [RTW-1:0] d_rem_reg [1:NDIV-1];
    logic [RTW-1:0] d_den_reg [1:NDIV-1];
    logic [QW-1:0]  d_q_reg   [1:NDIV];
    logic [RTW-1:0] d_rem_in  [0:NDIV-1];
    logic [RTW-1:0] d_den_in  [0:NDIV-1];
    logic [QW-1:0]  d_q_in    [0:NDIV-1];
    logic [RTW:0]   d_sh      [0:NDIV-1];
    logic           d_ge      [0:NDIV-1];
    logic [RTW-1:0] d_rem_nx  [0:NDIV-1];
    logic [QW-1:0]  d_q_nx    [0:NDIV-1];

    always_comb
    begin
        d_rem_in[0] = {1'b0, rho_w[RTW-1:1]};
        d_den_in[0] = r_w;
        d_q_in[0]   = '0;
        for (int s = 1; s < NDIV; s++)
        begin
            d_rem_in[s] = d_rem_reg[s];
            d_den_in[s] = d_den_reg[s];
            d_q_in[s]   = d_q_reg[s];
        end
        for (int s = 0; s < NDIV; s++)
        begin
            d_sh[s]     = {d_rem_in[s], (s == 0) ? rho_w[0] : 1'b0};
            d_ge[s]     = (d_sh[s] >= {1'b0, d_den_in[s]});
            d_rem_nx[s] = d_ge[s] ? RTW'(d_sh[s] - {1'b0, d_den_in[s]}) : d_sh[s][RTW-1:0];
            d_q_nx[s]   = {d_q_in[s][QW-2:0], d_ge[s]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < NDIV - 1; s++)
            begin
                d_rem_reg[s+1] <= d_rem_nx[s];
                d_den_reg[s+1] <= d_den_in[s];
            end
            for (int s = 0; s < NDIV; s++)
            begin
                d_q_reg[s+1] <= d_q_nx[s];
            end
        end
    end

    // back end: scale, offset, clamp
    function automatic logic signed [19:0] clamp_px(
        input logic signed [19:0] v,
        input logic signed [19:0] hi,
        input logic signed [19:0] cap
    );
        logic signed [19:0] c;
        c = v;
        if (c > hi)
            c = hi;
        if (c > cap)
            c = cap;
        if (c < 0)
            c = '0;
        return c;
    endfunction

    logic signed [63:0]            tc_reg;
    logic signed [49:0]            wp_reg;
    logic signed [63:0]            cm_reg;
    logic [ptpp_pkg::ROW_W-1:0]    row_mid_reg;
    logic [ptpp_pkg::COL_W-1:0]    col_out_reg;
    logic [ptpp_pkg::ROW_W-1:0]    row_out_reg;
    logic                          skip_out_reg;

    logic signed [AW-1:0]          t_w;
    logic signed [AW+QW:0]         tc_full;
    logic signed [49:0]            wp_full;
    logic signed [PW:0]            w_s;
    logic signed [63:0]            cm_full;
    logic signed [17:0]            row_off;
    logic signed [17:0]            col_off;
    logic signed [19:0]            row_v;
    logic signed [19:0]            col_v;
    logic signed [19:0]            row_c;
    logic signed [19:0]            col_c;

    always_comb
    begin
        w_s     = $signed({1'b0, pano_width_reg});
        t_w     = -ang_a_pipe[ST_QUO];
        tc_full = t_w * $signed({1'b0, d_q_reg[NDIV]});
        wp_full = w_s * ang_b_pipe[ST_QUO];
        cm_full = $signed(tc_reg[63:16]) * w_s;
        row_off = zero_reg[ST_QUO+1] ? 18'sd0 : $signed(wp_reg[49:32]);
        col_off = zero_reg[ST_OUT-1] ? 18'sd0 : $signed(cm_reg[63:46]);
        row_v   = 20'(row_off) + $signed(20'(pano_height_reg >> 1));
        col_v   = 20'(col_off) + $signed(20'(pano_width_reg >> 1));
        row_c   = clamp_px(row_v, $signed(20'(pano_height_reg)) - 20'sd1,
                           20'(ptpp_pkg::ROW_CAP));
        col_c   = clamp_px(col_v, $signed(20'(pano_width_reg)) - 20'sd1,
                           20'(ptpp_pkg::COL_CAP));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tc_reg       <= tc_full[63:0];
            wp_reg       <= wp_full;
            cm_reg       <= cm_full;
            row_mid_reg  <= row_c[ptpp_pkg::ROW_W-1:0];
            skip_out_reg <= skip_reg[ST_OUT-1];
            if (skip_reg[ST_OUT-1])
            begin
                col_out_reg <= '0;
                row_out_reg <= '0;
            end
            else
            begin
                col_out_reg <= col_c[ptpp_pkg::COL_W-1:0];
                row_out_reg <= row_mid_reg;
            end
        end
    end

    assign px.valid     = vld_reg[ST_OUT];
    assign px.pixel_col = col_out_reg;
    assign px.pixel_row = row_out_reg;
    assign px.skipped   = skip_out_reg;

    `PTPP_ASSERT_NOW(a_skip_zero, px.valid && px.skipped, px.pixel_col == '0 && px.pixel_row == '0)
    `PTPP_ASSERT_NOW(a_col_in_img, px.valid && !px.skipped && pano_width_reg != '0, 15'(px.pixel_col) < pano_width_reg)
    `PTPP_ASSERT_NOW(a_row_in_img, px.valid && !px.skipped && pano_height_reg != '0, 14'(px.pixel_row) < pano_height_reg)
    `PTPP_ASSERT_NXT(a_stall_hold, !adv, $stable(vld_reg))
    `PTPP_ASSERT_NXT(a_accept_enters, pt.valid && pt.ready, vld_reg[0])

endmodule
